// ----- rtl/core/msgpack_transaction_field_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the MessagePack transaction field decoder
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_TRANSACTION_FIELD_DECODER_MACROS_SVH
`define MSGPACK_TRANSACTION_FIELD_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define MTFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("decoder assertion failed");
`define MTFD_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("decoder forbidden condition seen");
`else
`define MTFD_ASSERT(lbl, prop)
`define MTFD_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/core/msgd_pkg.sv -----
// ----------------------------------------------------------------------------
// msgd_pkg
// Types, codes and key tables shared by the transaction field decoder.
// ----------------------------------------------------------------------------
package msgd_pkg;

  localparam int KEY_CHARS_DEF  = 31;
  localparam int TYPE_CHARS_DEF = 15;
  localparam int EVQ_DEPTH_DEF  = 4;
  localparam int NUM_KEYS       = 39;
  localparam int TOP_KEYS       = 28;
  localparam int NUM_TYPES      = 5;
  localparam int NAME_W         = 7;
  localparam int APB_AW         = 5;

  typedef enum logic [3:0] {
    PH_MAP, PH_KEY_HDR, PH_KEY_LEN, PH_KEY_CHARS, PH_VAL_HDR, PH_VSTR_LEN,
    PH_TYPE_CHARS, PH_UINT_BYTES, PH_BIN_HI, PH_BIN_LO, PH_DATA, PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    VK_UINT, VK_BOOL, VK_STR, VK_BINF, VK_BINV, VK_TYPE, VK_MAP
  } vkind_e;

  typedef enum logic [2:0] {
    EV_SCALAR = 3'd0, EV_START = 3'd1, EV_DATA = 3'd2, EV_DONE = 3'd3, EV_ERROR = 3'd4
  } evkind_e;

  typedef enum logic [2:0] {
    ER_EARLY = 3'd0, ER_TYPE = 3'd1, ER_LONG = 3'd2, ER_BINLEN = 3'd3,
    ER_KEY = 3'd4, ER_TTYPE = 3'd5
  } errkind_e;

  typedef enum logic [2:0] {
    REG_FIXED_BIN = 3'd0, REG_MAX_NOTE = 3'd1, REG_MAX_GEN = 3'd2,
    REG_MAX_UN = 3'd3, REG_MAX_AN = 3'd4, REG_MAX_URL = 3'd5
  } reg_e;

  localparam logic [5:0] FLD_TYPE = 6'd0;
  localparam logic [5:0] FLD_GEN  = 6'd6;
  localparam logic [5:0] FLD_UN   = 6'd31;
  localparam logic [5:0] FLD_AN   = 6'd32;

  localparam logic [7:0] MP_STR8   = 8'hd9;
  localparam logic [7:0] MP_BIN8   = 8'hc4;
  localparam logic [7:0] MP_BIN16  = 8'hc5;
  localparam logic [7:0] MP_FALSE  = 8'hc2;
  localparam logic [7:0] MP_TRUE   = 8'hc3;
  localparam logic [7:0] MP_UINT8  = 8'hcc;
  localparam logic [7:0] MP_UINT64 = 8'hcf;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  field;
    logic [63:0] value;
    logic [15:0] idx;
    logic [2:0]  err;
  } event_t;

  // Up to two events per byte; v1 is only set together with v0.
  typedef struct packed {
    logic   v0;
    logic   v1;
    event_t e0;
    event_t e1;
  } evpair_t;

  typedef struct packed {
    logic [7:0]  fixed_bin_len;
    logic [15:0] max_note_len;
    logic [7:0]  max_genesis_id_len;
    logic [7:0]  max_unit_name_len;
    logic [7:0]  max_asset_name_len;
    logic [7:0]  max_url_len;
  } cfg_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } evq_stat_t;

  localparam logic [NAME_W*8-1:0] KEY_NAME [NUM_KEYS] = '{
    "type", "snd", "rekey", "fee", "fv", "lv", "gen", "gh", "note", "amt",
    "rcv", "close", "selkey", "votekey", "votefst", "votelst", "votekd",
    "nonpart", "aamt", "aclose", "arcv", "asnd", "xaid", "faid", "fadd",
    "afrz", "caid", "apar",
    "t", "dc", "df", "un", "an", "au", "am", "m", "r", "f", "c"
  };

  localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
    3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd4, 3'd3,
    3'd3, 3'd5, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6,
    3'd7, 3'd4, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4,
    3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1
  };

  localparam vkind_e KEY_KIND [NUM_KEYS] = '{
    VK_TYPE, VK_BINF, VK_BINF, VK_UINT, VK_UINT, VK_UINT, VK_STR, VK_BINF, VK_BINV,
    VK_UINT, VK_BINF, VK_BINF, VK_BINF, VK_BINF, VK_UINT, VK_UINT, VK_UINT, VK_BOOL,
    VK_UINT, VK_BINF, VK_BINF, VK_BINF, VK_UINT, VK_UINT, VK_BINF, VK_BOOL, VK_UINT,
    VK_MAP,
    VK_UINT, VK_UINT, VK_BOOL, VK_STR, VK_STR, VK_STR, VK_BINF, VK_BINF, VK_BINF,
    VK_BINF, VK_BINF
  };

  localparam logic [NAME_W*8-1:0] TYPE_NAME [NUM_TYPES] = '{
    "pay", "keyreg", "axfer", "afrz", "acfg"
  };

  localparam logic [2:0] TYPE_LEN [NUM_TYPES] = '{3'd3, 3'd6, 3'd5, 3'd4, 3'd4};

  // Character at position pos of a name that is right-aligned in its vector.
  function automatic logic [7:0] name_char(logic [NAME_W*8-1:0] name, logic [2:0] len,
                                           logic [2:0] pos);
    logic [2:0] sel;
    sel = len - 3'd1 - pos;
    return name[{sel, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/core/msgpack_transaction_field_decoder.sv -----
// ----------------------------------------------------------------------------
// msgpack_transaction_field_decoder
// Decodes one MessagePack transaction record per buffer into field events.
// ----------------------------------------------------------------------------
// Input channel: push/full carries one record byte per transaction, with
// last_byte_i marking the end of the buffer. Result channel: empty/pop
// presents field events oldest first on event_kind_o, field_id_o, value_o,
// byte_index_o and error_kind_o.
// The classifier takes one byte per cycle. Each byte makes zero, one or
// two events, which enter the event queue at the accepting edge and reach
// the result ports in order. The queue takes two events per cycle
// but drains one, so a byte that makes two events costs one extra pop.
// full is raised while fewer than two queue entries are free; with a
// stalled receiver the queue fills and the input stalls behind it.
// Reset returns the decoder to expecting an outer map header, empties the
// queue and loads the registers with their defaults. After a byte flagged
// last_byte_i the decoder re-arms for the next record on its own.
// ----------------------------------------------------------------------------
`include "msgpack_transaction_field_decoder_macros.svh"

module msgpack_transaction_field_decoder import msgd_pkg::*; #(
  parameter int KEY_CHARS  = KEY_CHARS_DEF,
  parameter int TYPE_CHARS = TYPE_CHARS_DEF,
  parameter int EVQ_DEPTH  = EVQ_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_byte_i,
  input  logic              last_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        event_kind_o,
  output logic [5:0]        field_id_o,
  output logic [63:0]       value_o,
  output logic [15:0]       byte_index_o,
  output logic [2:0]        error_kind_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = $clog2(EVQ_DEPTH + 1);

  cfg_t          cfg;
  evpair_t       evp;
  evq_stat_t     wr;
  event_t        rd;
  logic          acc, rd_en;
  logic [CW-1:0] count;

  assign acc   = push && !full;
  assign rd_en = pop && !empty;
  assign wr.v0 = acc && evp.v0;
  assign wr.v1 = acc && evp.v1;

  msgd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msgd_front #(
    .KEY_CHARS  (KEY_CHARS),
    .TYPE_CHARS (TYPE_CHARS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .acc_i  (acc),
    .byte_i (in_byte_i),
    .last_i (last_byte_i),
    .evp_o  (evp)
  );

  msgd_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wr_e0_i (evp.e0),
    .wr_e1_i (evp.e1),
    .rd_i    (rd_en),
    .rd_o    (rd),
    .empty_o (empty),
    .full_o  (full),
    .count_o (count)
  );

  assign event_kind_o = rd.kind;
  assign field_id_o   = rd.field;
  assign value_o      = rd.value;
  assign byte_index_o = rd.idx;
  assign error_kind_o = rd.err;

  `MTFD_NEVER(a_evq_overflow, count > CW'(EVQ_DEPTH))
  `MTFD_NEVER(a_pair_packed, evp.v1 && !evp.v0)
  `MTFD_ASSERT(a_pop_only_drains, (rd_en && !wr.v0) |=> (count == $past(count) - CW'(1)))

endmodule

// ----- rtl/core/msgd_cfg.sv -----
// ----------------------------------------------------------------------------
// msgd_cfg
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module msgd_cfg import msgd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_FIXED_BIN: cfg_d.fixed_bin_len      = pwdata[7:0];
        REG_MAX_NOTE:  cfg_d.max_note_len       = pwdata[15:0];
        REG_MAX_GEN:   cfg_d.max_genesis_id_len = pwdata[7:0];
        REG_MAX_UN:    cfg_d.max_unit_name_len  = pwdata[7:0];
        REG_MAX_AN:    cfg_d.max_asset_name_len = pwdata[7:0];
        REG_MAX_URL:   cfg_d.max_url_len        = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FIXED_BIN: prdata = {24'd0, cfg_q.fixed_bin_len};
      REG_MAX_NOTE:  prdata = {16'd0, cfg_q.max_note_len};
      REG_MAX_GEN:   prdata = {24'd0, cfg_q.max_genesis_id_len};
      REG_MAX_UN:    prdata = {24'd0, cfg_q.max_unit_name_len};
      REG_MAX_AN:    prdata = {24'd0, cfg_q.max_asset_name_len};
      REG_MAX_URL:   prdata = {24'd0, cfg_q.max_url_len};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_bin_len      <= 8'd32;
      cfg_q.max_note_len       <= 16'd1024;
      cfg_q.max_genesis_id_len <= 8'd32;
      cfg_q.max_unit_name_len  <= 8'd8;
      cfg_q.max_asset_name_len <= 8'd32;
      cfg_q.max_url_len        <= 8'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/msgd_front.sv -----
// ----------------------------------------------------------------------------
// msgd_front
// Byte classifier: walks the map structure one byte per transaction and
// produces up to two events for the event queue.
// ----------------------------------------------------------------------------
module msgd_front import msgd_pkg::*; #(
  parameter int KEY_CHARS  = KEY_CHARS_DEF,
  parameter int TYPE_CHARS = TYPE_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output evpair_t    evp_o
);

  localparam int MAXC = (KEY_CHARS > TYPE_CHARS) ? KEY_CHARS : TYPE_CHARS;
  localparam int LW   = $clog2(MAXC + 1);

  phase_e                 phase_q, phase_d;
  logic [3:0]             outer_q, outer_d, inner_q, inner_d;
  logic                   in_inner_q, in_inner_d;
  logic [LW-1:0]          klen_q, klen_d;
  logic [5:0]             field_q, field_d;
  logic [15:0]            left_q, left_d;
  logic [63:0]            acc_q, acc_d;
  logic                   fin_q, fin_d;
  logic [NUM_KEYS-1:0]    kcand_q, kcand_d, kcand_upd;
  logic [NUM_TYPES-1:0]   tcand_q, tcand_d, tcand_upd;

  logic [LW-1:0]          pos;
  vkind_e                 vk;
  logic                   do_fail, do_pair, main_v, done_v;
  errkind_e               fail_code;
  event_t                 main_e;
  logic                   key_go, vstr_go, bin_go, start_go;
  logic [7:0]             len8, vlimit;
  logic [15:0]            len16;
  logic                   kmatch, tmatch;
  logic [5:0]             kidx;
  logic [2:0]             tidx;
  logic [63:0]            acc_shift;
  event_t                 e1;
  logic                   v1;

  assign pos       = klen_q - left_q[LW-1:0];
  assign vk        = (field_q < 6'(NUM_KEYS)) ? KEY_KIND[field_q] : VK_UINT;
  assign acc_shift = {acc_q[55:0], byte_i};

  // Incremental name matching: each table entry stays a candidate while
  // every character received so far equals its character at that position.
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      kcand_upd[i] = kcand_q[i] && (pos < LW'(KEY_LEN[i])) &&
                     (name_char(KEY_NAME[i], KEY_LEN[i], pos[2:0]) == byte_i);
    end
    for (int j = 0; j < NUM_TYPES; j++) begin
      tcand_upd[j] = tcand_q[j] && (pos < LW'(TYPE_LEN[j])) &&
                     (name_char(TYPE_NAME[j], TYPE_LEN[j], pos[2:0]) == byte_i);
    end
  end

  always_comb begin
    kmatch = 1'b0;
    kidx   = 6'd0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (kcand_upd[i] && (LW'(KEY_LEN[i]) == klen_q) &&
          ((i >= TOP_KEYS) == in_inner_q)) begin
        kmatch = 1'b1;
        kidx   = 6'(i);
      end
    end
    tmatch = 1'b0;
    tidx   = 3'd0;
    for (int j = NUM_TYPES - 1; j >= 0; j--) begin
      if (tcand_upd[j] && (LW'(TYPE_LEN[j]) == klen_q)) begin
        tmatch = 1'b1;
        tidx   = 3'(j);
      end
    end
  end

  always_comb begin
    unique case (field_q)
      FLD_TYPE: vlimit = 8'(TYPE_CHARS);
      FLD_GEN:  vlimit = cfg_i.max_genesis_id_len;
      FLD_UN:   vlimit = cfg_i.max_unit_name_len;
      FLD_AN:   vlimit = cfg_i.max_asset_name_len;
      default:  vlimit = cfg_i.max_url_len;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    outer_d    = outer_q;
    inner_d    = inner_q;
    in_inner_d = in_inner_q;
    klen_d     = klen_q;
    field_d    = field_q;
    left_d     = left_q;
    acc_d      = acc_q;
    fin_d      = fin_q;
    kcand_d    = kcand_q;
    tcand_d    = tcand_q;
    do_fail    = 1'b0;
    fail_code  = ER_EARLY;
    do_pair    = 1'b0;
    main_v     = 1'b0;
    main_e     = '0;
    done_v     = 1'b0;
    key_go     = 1'b0;
    vstr_go    = 1'b0;
    bin_go     = 1'b0;
    start_go   = 1'b0;
    len8       = byte_i;
    len16      = {8'd0, byte_i};

    unique case (phase_q)
      PH_MAP: begin
        if (byte_i[7:4] != 4'h8) begin
          do_fail = 1'b1; fail_code = ER_TYPE;
        end else begin
          outer_d = byte_i[3:0];
          if (byte_i[3:0] == 4'd0) begin
            main_v      = 1'b1;
            main_e.kind = EV_DONE;
            phase_d     = PH_IDLE;
            fin_d       = 1'b1;
          end else begin
            phase_d = PH_KEY_HDR;
          end
        end
      end
      PH_KEY_HDR: begin
        if (byte_i[7:5] == 3'b101) begin
          key_go = 1'b1; len8 = {3'd0, byte_i[4:0]};
        end else if (byte_i == MP_STR8) begin
          phase_d = PH_KEY_LEN;
        end else begin
          do_fail = 1'b1; fail_code = ER_TYPE;
        end
      end
      PH_KEY_LEN: key_go = 1'b1;
      PH_KEY_CHARS: begin
        kcand_d = kcand_upd;
        left_d  = left_q - 16'd1;
        if (left_q == 16'd1) begin
          if (kmatch) begin
            field_d = kidx;
            phase_d = PH_VAL_HDR;
          end else begin
            do_fail = 1'b1; fail_code = ER_KEY;
          end
        end
      end
      PH_TYPE_CHARS: begin
        tcand_d = tcand_upd;
        left_d  = left_q - 16'd1;
        if (left_q == 16'd1) begin
          if (tmatch) begin
            main_v       = 1'b1;
            main_e.kind  = EV_SCALAR;
            main_e.field = field_q;
            main_e.value = {61'd0, tidx};
            do_pair      = 1'b1;
          end else begin
            do_fail = 1'b1; fail_code = ER_TTYPE;
          end
        end
      end
      PH_VAL_HDR: begin
        unique case (vk)
          VK_UINT: begin
            if (!byte_i[7]) begin
              main_v       = 1'b1;
              main_e.kind  = EV_SCALAR;
              main_e.field = field_q;
              main_e.value = {56'd0, byte_i};
              do_pair      = 1'b1;
            end else if (byte_i >= MP_UINT8 && byte_i <= MP_UINT64) begin
              left_d  = 16'd1 << byte_i[1:0];
              acc_d   = 64'd0;
              phase_d = PH_UINT_BYTES;
            end else begin
              do_fail = 1'b1; fail_code = ER_TYPE;
            end
          end
          VK_BOOL: begin
            if (byte_i == MP_TRUE || byte_i == MP_FALSE) begin
              main_v       = 1'b1;
              main_e.kind  = EV_SCALAR;
              main_e.field = field_q;
              main_e.value = {63'd0, byte_i == MP_TRUE};
              do_pair      = 1'b1;
            end else begin
              do_fail = 1'b1; fail_code = ER_TYPE;
            end
          end
          VK_STR, VK_TYPE: begin
            if (byte_i[7:5] == 3'b101) begin
              vstr_go = 1'b1; len8 = {3'd0, byte_i[4:0]};
            end else if (byte_i == MP_STR8) begin
              phase_d = PH_VSTR_LEN;
            end else begin
              do_fail = 1'b1; fail_code = ER_TYPE;
            end
          end
          VK_BINF, VK_BINV: begin
            acc_d = 64'd0;
            if (byte_i == MP_BIN8) begin
              phase_d = PH_BIN_LO;
            end else if (byte_i == MP_BIN16 && vk == VK_BINV) begin
              phase_d = PH_BIN_HI;
            end else begin
              do_fail = 1'b1; fail_code = ER_TYPE;
            end
          end
          default: begin
            if (byte_i[7:4] != 4'h8) begin
              do_fail = 1'b1; fail_code = ER_TYPE;
            end else if (byte_i[3:0] == 4'd0) begin
              do_pair = 1'b1;
            end else begin
              in_inner_d = 1'b1;
              inner_d    = byte_i[3:0];
              phase_d    = PH_KEY_HDR;
            end
          end
        endcase
      end
      PH_VSTR_LEN: vstr_go = 1'b1;
      PH_UINT_BYTES: begin
        acc_d  = acc_shift;
        left_d = left_q - 16'd1;
        if (left_q == 16'd1) begin
          main_v       = 1'b1;
          main_e.kind  = EV_SCALAR;
          main_e.field = field_q;
          main_e.value = acc_shift;
          do_pair      = 1'b1;
        end
      end
      PH_BIN_HI: begin
        acc_d   = {56'd0, byte_i};
        phase_d = PH_BIN_LO;
      end
      PH_BIN_LO: begin
        bin_go = 1'b1;
        len16  = {acc_q[7:0], byte_i};
      end
      PH_DATA: begin
        main_v       = 1'b1;
        main_e.kind  = EV_DATA;
        main_e.field = field_q;
        main_e.value = {56'd0, byte_i};
        main_e.idx   = acc_q[15:0] - left_q;
        left_d       = left_q - 16'd1;
        if (left_q == 16'd1) do_pair = 1'b1;
      end
      default: ;
    endcase

    if (key_go) begin
      if (len8 > 8'(KEY_CHARS)) begin
        do_fail = 1'b1; fail_code = ER_LONG;
      end else if (len8 == 8'd0) begin
        do_fail = 1'b1; fail_code = ER_KEY;
      end else begin
        klen_d  = LW'(len8);
        left_d  = {8'd0, len8};
        kcand_d = '1;
        phase_d = PH_KEY_CHARS;
      end
    end

    if (vstr_go) begin
      if (len8 > vlimit) begin
        do_fail = 1'b1; fail_code = ER_LONG;
      end else if (field_q == FLD_TYPE) begin
        if (len8 == 8'd0) begin
          do_fail = 1'b1; fail_code = ER_TTYPE;
        end else begin
          klen_d  = LW'(len8);
          left_d  = {8'd0, len8};
          tcand_d = '1;
          phase_d = PH_TYPE_CHARS;
        end
      end else begin
        start_go = 1'b1;
        len16    = {8'd0, len8};
      end
    end

    if (bin_go) begin
      if (vk == VK_BINF && len16 != {8'd0, cfg_i.fixed_bin_len}) begin
        do_fail = 1'b1; fail_code = ER_BINLEN;
      end else if (vk == VK_BINV && len16 > cfg_i.max_note_len) begin
        do_fail = 1'b1; fail_code = ER_LONG;
      end else begin
        start_go = 1'b1;
      end
    end

    if (start_go) begin
      main_v       = 1'b1;
      main_e.kind  = EV_START;
      main_e.field = field_q;
      main_e.value = {48'd0, len16};
      acc_d        = {48'd0, len16};
      left_d       = len16;
      if (len16 == 16'd0) do_pair = 1'b1;
      else                phase_d = PH_DATA;
    end

    if (do_fail) begin
      main_v     = 1'b1;
      main_e     = '0;
      main_e.kind = EV_ERROR;
      main_e.err = fail_code;
      phase_d    = PH_IDLE;
      fin_d      = 1'b1;
    end

    // A completed pair closes the inner map first, then the outer one.
    if (do_pair) begin
      if (in_inner_q && inner_q != 4'd1) begin
        inner_d = inner_q - 4'd1;
        phase_d = PH_KEY_HDR;
      end else begin
        if (in_inner_q) begin
          inner_d    = inner_q - 4'd1;
          in_inner_d = 1'b0;
        end
        outer_d = outer_q - 4'd1;
        if (outer_q != 4'd1) begin
          phase_d = PH_KEY_HDR;
        end else begin
          done_v  = 1'b1;
          phase_d = PH_IDLE;
          fin_d   = 1'b1;
        end
      end
    end

    v1 = done_v;
    e1 = '0;
    e1.kind = EV_DONE;
    if (last_i && !fin_d) begin
      v1      = 1'b1;
      e1.kind = EV_ERROR;
      e1.err  = ER_EARLY;
    end

    if (last_i) begin
      phase_d    = PH_MAP;
      outer_d    = 4'd0;
      inner_d    = 4'd0;
      in_inner_d = 1'b0;
      klen_d     = '0;
      field_d    = 6'd0;
      left_d     = 16'd0;
      acc_d      = 64'd0;
      fin_d      = 1'b0;
    end

    // Keep the queue write packed: a lone second event moves to slot zero.
    evp_o.v0 = main_v || v1;
    evp_o.v1 = main_v && v1;
    evp_o.e0 = main_v ? main_e : e1;
    evp_o.e1 = e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAP;
      outer_q    <= 4'd0;
      inner_q    <= 4'd0;
      in_inner_q <= 1'b0;
      klen_q     <= '0;
      field_q    <= 6'd0;
      left_q     <= 16'd0;
      acc_q      <= 64'd0;
      fin_q      <= 1'b0;
      kcand_q    <= '0;
      tcand_q    <= '0;
    end else if (acc_i) begin
      phase_q    <= phase_d;
      outer_q    <= outer_d;
      inner_q    <= inner_d;
      in_inner_q <= in_inner_d;
      klen_q     <= klen_d;
      field_q    <= field_d;
      left_q     <= left_d;
      acc_q      <= acc_d;
      fin_q      <= fin_d;
      kcand_q    <= kcand_d;
      tcand_q    <= tcand_d;
    end
  end

endmodule

// ----- rtl/core/msgd_evq.sv -----
// ----------------------------------------------------------------------------
// msgd_evq
// Event queue between the byte classifier and the result port. Takes up to
// two events per cycle and hands out one.
// ----------------------------------------------------------------------------
module msgd_evq import msgd_pkg::*; #(
  parameter int DEPTH = EVQ_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  evq_stat_t                  wr_i,
  input  event_t                     wr_e0_i,
  input  event_t                     wr_e1_i,
  input  logic                       rd_i,
  output event_t                     rd_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  event_t        mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CW-1:0] cnt_q, cnt_d, nwr;

  assign wp1     = wp_q + PW'(1);
  assign nwr     = CW'(wr_i.v0) + CW'(wr_i.v1);
  assign rd_o    = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  // A byte may bring two events, so keep two entries free.
  assign full_o  = (cnt_q > CW'(DEPTH - 2));
  assign count_o = cnt_q;

  always_comb begin
    wp_d  = wp_q + PW'(nwr);
    rp_d  = rp_q + PW'(rd_i);
    cnt_d = cnt_q + nwr - CW'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.v0) mem_q[wp_q] <= wr_e0_i;
    if (wr_i.v1) mem_q[wp1]  <= wr_e1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
